// File: rtl/assert_macros.svh
// Assertion helpers for the keyboard controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KSCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kscc assertion failed");

`define KSCC_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("kscc forbidden condition seen");

`else

`define KSCC_ASSERT(lbl, clk, rst, prop)

`define KSCC_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: rtl/kscc_pkg.sv
package kscc_pkg;

   typedef enum logic [1:0] {
      ACT_PRESS   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_HOST    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_DELAY = 2'd1,
      PEND_LED   = 2'd2
   } pend_type;

   typedef enum logic {
      JOB_SINGLE = 1'b0,
      JOB_ID     = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   tx_byte;
   } job_type;

   typedef struct packed {
      logic       active;
      logic [6:0] key;
      logic [9:0] countdown;
      logic       phase;
      pend_type   pending;
      logic [9:0] first_delay;
   } rpt_state_type;

   localparam int unsigned KEY_ROWS = 16;

   localparam logic CSR_MODEL  = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   localparam logic [6:0] CODE_HELP  = 7'h3f;
   localparam logic [6:0] CODE_CAPS  = 7'h71;
   localparam logic [6:0] CODE_KANA  = 7'h72;
   localparam logic [7:0] BYTE_ACK   = 8'hfa;
   localparam logic [7:0] BYTE_NACK  = 8'hfc;
   localparam logic [7:0] CMD_DELAY  = 8'h9c;
   localparam logic [7:0] CMD_LED    = 8'h9d;
   localparam logic [7:0] CMD_ID     = 8'h9f;
   localparam logic [7:0] ID_FIRST   = 8'ha0;
   localparam logic [7:0] ID_SECOND  = 8'h80;
   localparam logic [7:0] HOST_RESET = 8'hff;

   localparam logic [9:0] DELAY_DEFAULT = 10'd500;
   localparam logic [7:0] PERIOD_RESET  = 8'd60;

   function automatic logic [9:0] delay_lookup(input logic [1:0] sel);
      logic [9:0] d;
      case (sel)
         2'd0:    d = 10'd250;
         2'd1:    d = 10'd500;
         2'd2:    d = 10'd500;
         default: d = 10'd1000;
      endcase
      return d;
   endfunction

endpackage

// File: rtl/kscc_front.sv
module kscc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kscc_pkg::action_type req_action,
   input  logic [3:0]           req_key_row,
   input  logic [2:0]           req_key_column,
   input  logic [7:0]           req_host_byte,
   input  logic                 cfg_model,
   input  logic [7:0]           cfg_period,
   output logic                 push_valid,
   output kscc_pkg::job_type    push_job,
   input  logic                 push_ready
);
   import kscc_pkg::*;

   rpt_state_type st_ff, st_in;
   logic          emit;
   job_type       job;
   logic [6:0]    code;
   logic          row_ok;
   logic [7:0]    period;
   logic [7:0]    cmd;
   logic          accept;

   assign code   = {req_key_row, req_key_column};
   assign row_ok = {1'b0, req_key_row} < 5'(KEY_ROWS);
   assign period = (cfg_period == 8'd0) ? 8'd1 : cfg_period;
   assign cmd    = (st_ff.pending == PEND_DELAY) ? CMD_DELAY : CMD_LED;
   assign accept = req_valid && req_ready;

   always_comb begin
      st_in = st_ff;
      emit  = 1'b0;
      job   = '{kind: JOB_SINGLE, tx_byte: 8'h00};
      case (req_action)
         ACT_PRESS: begin
            if (row_ok) begin
               emit        = 1'b1;
               job.tx_byte = {1'b0, code};
               if (cfg_model) begin
                  if (code == CODE_HELP) begin
                     st_in.active    = 1'b1;
                     st_in.key       = code;
                     st_in.phase     = 1'b0;
                     st_in.countdown = st_ff.first_delay;
                  end
               end else if (code != CODE_CAPS && code != CODE_KANA) begin
                  st_in.active    = 1'b1;
                  st_in.key       = code;
                  st_in.phase     = 1'b0;
                  st_in.countdown = DELAY_DEFAULT;
               end
            end
         end
         ACT_RELEASE: begin
            if (row_ok) begin
               if (st_ff.active && st_ff.key == code) begin
                  st_in.active = 1'b0;
               end
               emit        = 1'b1;
               job.tx_byte = {1'b1, code};
            end
         end
         ACT_TICK: begin
            if (st_ff.active) begin
               if (st_ff.countdown <= 10'd1) begin
                  st_in.countdown = {2'b00, period};
                  if (cfg_model) begin
                     st_in.phase = ~st_ff.phase;
                     emit        = 1'b1;
                     job.tx_byte = {~st_ff.phase, st_ff.key};
                  end
               end else begin
                  st_in.countdown = st_ff.countdown - 10'd1;
               end
            end
         end
         ACT_HOST: begin
            if (cfg_model) begin
               if (st_ff.pending == PEND_DELAY || st_ff.pending == PEND_LED) begin
                  if (req_host_byte != cmd) begin
                     if (st_ff.pending == PEND_DELAY) begin
                        st_in.first_delay = delay_lookup(req_host_byte[6:5]);
                     end
                     st_in.pending = PEND_NONE;
                     emit          = 1'b1;
                     job.tx_byte   = BYTE_ACK;
                  end
               end else begin
                  st_in.pending = PEND_NONE;
                  emit          = 1'b1;
                  case (req_host_byte)
                     CMD_DELAY: begin
                        st_in.pending = PEND_DELAY;
                        job.tx_byte   = BYTE_ACK;
                     end
                     CMD_LED: begin
                        st_in.pending = PEND_LED;
                        job.tx_byte   = BYTE_ACK;
                     end
                     CMD_ID: begin
                        job.kind    = JOB_ID;
                        job.tx_byte = BYTE_ACK;
                     end
                     default: begin
                        job.tx_byte = BYTE_NACK;
                     end
                  endcase
               end
            end else if (req_host_byte == HOST_RESET) begin
               st_in.active    = 1'b0;
               st_in.countdown = 10'd0;
               st_in.phase     = 1'b0;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && emit;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{active: 1'b0, key: 7'd0, countdown: 10'd0, phase: 1'b0,
                    pending: PEND_NONE, first_delay: DELAY_DEFAULT};
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

endmodule

// File: rtl/kscc_queue.sv
module kscc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  kscc_pkg::job_type push_job,
   output logic              push_ready,
   output logic              head_valid,
   output kscc_pkg::job_type head_job,
   input  logic              pop
);
   import kscc_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/kscc_back.sv
module kscc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  kscc_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last
);
   import kscc_pkg::*;

   job_type    cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       taken;

   always_comb begin
      rsp_last    = 1'b1;
      rsp_tx_byte = cur_ff.tx_byte;
      if (cur_ff.kind == JOB_ID) begin
         case (idx_ff)
            2'd0:    begin rsp_tx_byte = cur_ff.tx_byte; rsp_last = 1'b0; end
            2'd1:    begin rsp_tx_byte = ID_FIRST;       rsp_last = 1'b0; end
            default: begin rsp_tx_byte = ID_SECOND;      rsp_last = 1'b1; end
         endcase
      end
   end

   assign rsp_valid = valid_ff;
   assign taken     = valid_ff && rsp_ready;
   assign pop       = head_valid && (!valid_ff || (taken && rsp_last));

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (pop) begin
         cur_in   = head_job;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (taken && rsp_last) begin
         valid_in = 1'b0;
      end else if (taken) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// File: rtl/keyboard_scancode_command_ctrl_core.sv
// An accepted item that yields bytes is queued as a job; the back end registers its bytes onto the result side.
// Throughput: one item per cycle is accepted while the job queue has room; the result
// side sends one byte per cycle while rsp_ready is high; a job is one byte, or three for an ID reply.
// The queue depth sets how far the accepting side can run ahead of the sending side.
// Synchronous active-high reset clears the repeat timer, pending command and queue,
// and restores model 1, a 60 ms period and a 500 ms first delay.
`include "assert_macros.svh"

module keyboard_scancode_command_ctrl_core #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [3:0] req_key_row,
   input  logic [2:0] req_key_column,
   input  logic [7:0] req_host_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import kscc_pkg::*;

   logic       model_ff;
   logic [7:0] period_ff;
   logic       push_valid;
   job_type    push_job;
   logic       push_ready;
   logic       head_valid;
   job_type    head_job;
   logic       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff  <= 1'b1;
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODEL:  model_ff  <= csr_wdata[0];
            CSR_PERIOD: period_ff <= csr_wdata;
            default:    period_ff <= period_ff;
         endcase
      end
   end

   kscc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (action_type'(req_action)),
      .req_key_row    (req_key_row),
      .req_key_column (req_key_column),
      .req_host_byte  (req_host_byte),
      .cfg_model      (model_ff),
      .cfg_period     (period_ff),
      .push_valid     (push_valid),
      .push_job       (push_job),
      .push_ready     (push_ready)
   );

   kscc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   kscc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

   `KSCC_ASSERT(a_more_follows, clock, reset, (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
   `KSCC_ASSERT(a_head_loaded, clock, reset, (head_valid && !rsp_valid) |=> rsp_valid)
   `KSCC_NEVER(a_pop_empty, clock, reset, pop && !head_valid)

endmodule

// File: verif/tb_keyboard_scancode_command_ctrl_core.sv
module tb_keyboard_scancode_command_ctrl_core;
   timeunit 1ns;
   timeprecision 1ps;

   import kscc_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } tx_entry_type;

   class kbd_scoreboard;
      logic         model;
      logic [7:0]   period_ms;
      logic         rpt_on;
      logic [6:0]   rpt_code;
      logic [9:0]   rpt_left;
      logic         rpt_break;
      pend_type     pend;
      logic [9:0]   delay_ms;
      tx_entry_type owed[$];
      int           errors;

      function new();
         model = 1'b1;
         period_ms = PERIOD_RESET;
         rpt_on = 1'b0;
         rpt_code = '0;
         rpt_left = '0;
         rpt_break = 1'b0;
         pend = PEND_NONE;
         delay_ms = DELAY_DEFAULT;
         errors = 0;
      endfunction

      function void set_reg(logic idx, logic [7:0] v);
         if (idx == CSR_MODEL) begin
            model = v[0];
         end else begin
            period_ms = v;
         end
      endfunction

      function logic [9:0] delay_for(logic [1:0] sel);
         case (sel)
            2'd0: return 10'd250;
            2'd3: return 10'd1000;
            default: return 10'd500;
         endcase
      endfunction

      function void start_repeat(logic [6:0] code, logic [9:0] d);
         rpt_on = 1'b1;
         rpt_code = code;
         rpt_break = 1'b0;
         rpt_left = d;
      endfunction

      function void note_item(action_type act, logic [3:0] row, logic [2:0] col,
                              logic [7:0] hb);
         logic [7:0]   bytes[$];
         logic [6:0]   code;
         logic [7:0]   cmd;
         tx_entry_type e;
         code = {row, col};
         case (act)
            ACT_PRESS: begin
               bytes.push_back({1'b0, code});
               if (model) begin
                  if (code == CODE_HELP) start_repeat(code, delay_ms);
               end else if (code != CODE_CAPS && code != CODE_KANA) begin
                  start_repeat(code, DELAY_DEFAULT);
               end
            end
            ACT_RELEASE: begin
               if (rpt_on && rpt_code == code) rpt_on = 1'b0;
               bytes.push_back({1'b1, code});
            end
            ACT_TICK: begin
               if (rpt_on) begin
                  if (rpt_left <= 10'd1) begin
                     rpt_left = (period_ms == 8'd0) ? 10'd1 : {2'b00, period_ms};
                     if (model) begin
                        rpt_break = ~rpt_break;
                        bytes.push_back({rpt_break, rpt_code});
                     end
                  end else begin
                     rpt_left = rpt_left - 10'd1;
                  end
               end
            end
            default: begin
               if (model) begin
                  if (pend != PEND_NONE) begin
                     cmd = (pend == PEND_DELAY) ? CMD_DELAY : CMD_LED;
                     if (hb != cmd) begin
                        if (pend == PEND_DELAY) delay_ms = delay_for(hb[6:5]);
                        pend = PEND_NONE;
                        bytes.push_back(BYTE_ACK);
                     end
                  end else begin
                     case (hb)
                        CMD_DELAY: begin
                           pend = PEND_DELAY;
                           bytes.push_back(BYTE_ACK);
                        end
                        CMD_LED: begin
                           pend = PEND_LED;
                           bytes.push_back(BYTE_ACK);
                        end
                        CMD_ID: begin
                           bytes.push_back(BYTE_ACK);
                           bytes.push_back(ID_FIRST);
                           bytes.push_back(ID_SECOND);
                        end
                        default: bytes.push_back(BYTE_NACK);
                     endcase
                  end
               end else if (hb == HOST_RESET) begin
                  rpt_on = 1'b0;
                  rpt_left = '0;
                  rpt_break = 1'b0;
               end
            end
         endcase
         foreach (bytes[i]) begin
            e.tx_byte = bytes[i];
            e.last = (i == bytes.size() - 1);
            owed.push_back(e);
         end
      endfunction

      function void check_byte(logic [7:0] b, logic l);
         tx_entry_type e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %02h last %0b", $time, b, l);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (b !== e.tx_byte) begin
            $display("%0t: tx_byte mismatch, expected %02h, actual %02h", $time, e.tx_byte, b);
            errors++;
         end
         if (l !== e.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, l);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [3:0] req_key_row;
   logic [2:0] req_key_column;
   logic [7:0] req_host_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last;
   logic       csr_we;
   logic       csr_index;
   logic [7:0] csr_wdata;
   bit         bursts_on = 1'b1;

   kbd_scoreboard sb = new();

   keyboard_scancode_command_ctrl_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_key_row    (req_key_row),
      .req_key_column (req_key_column),
      .req_host_byte  (req_host_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_byte(rsp_tx_byte, rsp_last);
         if (req_valid && req_ready) begin
            sb.note_item(action_type'(req_action), req_key_row, req_key_column,
                         req_host_byte);
         end
      end
   end

   initial begin
      forever begin
         if (bursts_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      #2ms;
      $display("keyboard_scancode_command_ctrl_core regression: fail");
      $finish;
   end

   task automatic send_item(action_type act, logic [3:0] row, logic [2:0] col,
                            logic [7:0] hb);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key_row <= row;
      req_key_column <= col;
      req_host_byte <= hb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic key_event(action_type act, logic [3:0] row, logic [2:0] col);
      send_item(act, row, col, 8'($urandom_range(0, 255)));
   endtask

   task automatic host_event(logic [7:0] hb);
      send_item(ACT_HOST, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), hb);
   endtask

   task automatic tick_event();
      send_item(ACT_TICK, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      csr_we <= 1'b0;
   endtask

   task automatic random_key(action_type act);
      if ($urandom_range(0, 4) == 0) begin
         key_event(act, 4'd7, 3'd7);
      end else if ($urandom_range(0, 9) == 0) begin
         key_event(act, 4'd14, 3'($urandom_range(1, 2)));
      end else begin
         key_event(act, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      end
   endtask

   task automatic host_sequence();
      logic [7:0] cmd;
      case ($urandom_range(0, 5))
         0, 1: begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_DELAY : CMD_LED;
            host_event(cmd);
            if ($urandom_range(0, 3) == 0) host_event(cmd);
            host_event(8'($urandom_range(0, 255)));
         end
         2: host_event(CMD_ID);
         3: host_event(HOST_RESET);
         default: host_event(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic random_mix(int n);
      int k;
      int pick;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) random_key(ACT_PRESS);
         else if (pick < 45) random_key(ACT_RELEASE);
         else if (pick < 70) tick_event();
         else host_sequence();
      end
   endtask

   task automatic tick_run(int n, int noise_pct);
      int k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            if ($urandom_range(0, 1) == 0) random_key(ACT_PRESS);
            else host_sequence();
         end else begin
            tick_event();
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_PRESS;
      req_key_row <= '0;
      req_key_column <= '0;
      req_host_byte <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_MODEL;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      key_event(ACT_PRESS, 4'd0, 3'd0);
      key_event(ACT_PRESS, 4'd15, 3'd7);
      key_event(ACT_RELEASE, 4'd15, 3'd7);
      tick_event();
      host_event(CMD_ID);
      host_event(8'h00);
      host_event(HOST_RESET);
      host_event(CMD_DELAY);
      host_event(CMD_DELAY);
      host_event(8'he0);
      host_event(CMD_LED);
      host_event(CMD_LED);
      host_event(CMD_ID);
      host_event(CMD_DELAY);
      host_event(8'h5f);
      host_event(CMD_DELAY);
      host_event(8'h1f);
      key_event(ACT_PRESS, 4'd7, 3'd7);
      key_event(ACT_RELEASE, 4'd7, 3'd6);
      key_event(ACT_RELEASE, 4'd7, 3'd7);
      wait_idle();
      write_reg(CSR_MODEL, 8'd0);
      key_event(ACT_PRESS, 4'd14, 3'd1);
      key_event(ACT_PRESS, 4'd14, 3'd2);
      host_event(8'h12);
      key_event(ACT_PRESS, 4'd3, 3'd3);
      host_event(HOST_RESET);
      wait_idle();

      write_reg(CSR_MODEL, 8'd1);
      write_reg(CSR_PERIOD, 8'($urandom_range(1, 255)));
      random_mix(10);
      wait_idle();

      write_reg(CSR_PERIOD, 8'd0);
      host_event(8'h00);
      host_event(CMD_DELAY);
      host_event(8'($urandom_range(0, 255)) & 8'h1f);
      key_event(ACT_PRESS, 4'd7, 3'd7);
      tick_run(254, 0);
      wait_idle();
      write_reg(CSR_MODEL, 8'd0);
      tick_run(4, 0);
      wait_idle();
      write_reg(CSR_MODEL, 8'd1);
      tick_run(4, 0);
      wait_idle();

      bursts_on = 1'b0;
      write_reg(CSR_PERIOD, 8'd255);
      random_mix(10);
      wait_idle();

      if (sb.errors == 0) begin
         $display("keyboard_scancode_command_ctrl_core regression: pass");
      end else begin
         $display("keyboard_scancode_command_ctrl_core regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/kscc_pkg.sv
rtl/kscc_front.sv
rtl/kscc_queue.sv
rtl/kscc_back.sv
rtl/keyboard_scancode_command_ctrl_core.sv
verif/tb_keyboard_scancode_command_ctrl_core.sv
